// ===== rtl/midi_note_count_trigger_table_assert.svh =====
// Assertion macros for the note-count trigger table.
// Used by the back-end sequencer; no other dependencies.
`ifndef MIDI_NOTE_COUNT_TRIGGER_TABLE_ASSERT_SVH
`define MIDI_NOTE_COUNT_TRIGGER_TABLE_ASSERT_SVH
`ifndef SYNTH
`define MNCT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MNCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MNCT_ASSERT(lbl, clk, rst, prop, msg)
`define MNCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/mnct_pkg.sv =====
// Shared types and constants of the note-count trigger table.
// No dependencies.
package mnct_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_BITS = 7;
  localparam int DEF_MAX_TRIGGERS = 32;
  localparam int DEF_COUNT_BITS = 16;
  localparam int QDEPTH = 2;
  localparam logic [6:0] MIN_VEL_RESET = 7'd1;

  typedef enum logic [1:0] {
    OP_NOTE    = 2'd0,
    OP_ADD     = 2'd1,
    OP_CLR_CNT = 2'd2,
    OP_CLR_ALL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACTION = 2'd0,
    KIND_NEXT   = 2'd1,
    KIND_ADDED  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [15:0] reps;
    logic [7:0]  act;
    logic        has_act;
    logic        nxt;
    logic        shape_ok;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  note;
    logic [15:0] reps;
    logic [7:0]  act;
    logic        has_act;
    logic        nxt;
    logic [15:0] id;
  } trig_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  act;
    logic [15:0] id;
    logic [6:0]  note;
    logic        last;
  } res_t;

endpackage

// ===== rtl/mnct_if.sv =====
// Channel interfaces: request input, result output, config write.
// No dependencies.
interface mnct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [15:0] repeats;
  logic [7:0]  action_id;
  logic        has_action;
  logic        next_flag;
  modport source (output valid, mode, note, velocity, repeats, action_id, has_action,
                  next_flag, input ready);
  modport sink (input valid, mode, note, velocity, repeats, action_id, has_action,
                next_flag, output ready);
endinterface

interface mnct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  action_id_res;
  logic [15:0] trigger_id;
  logic [6:0]  note_res;
  logic        last;
  modport source (output valid, kind, action_id_res, trigger_id, note_res, last,
                  input ready);
  modport sink (input valid, kind, action_id_res, trigger_id, note_res, last,
                output ready);
endinterface

interface mnct_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] min_velocity;
  modport source (output valid, min_velocity, input ready);
  modport sink (input valid, min_velocity, output ready);
endinterface

// ===== rtl/mnct_front.sv =====
// Front end: accepts requests and decodes them into queue commands.
// Depends on mnct_pkg and mnct_in_if.
module mnct_front import mnct_pkg::*; (
  mnct_in_if.sink  in_ch,
  input  logic     q_ready,
  output logic     q_valid,
  output cmd_t     q_cmd
);
  assign in_ch.ready = q_ready;
  assign q_valid = in_ch.valid;

  always_comb begin
    q_cmd.op       = op_t'(in_ch.mode);
    q_cmd.note     = in_ch.note;
    q_cmd.vel      = in_ch.velocity;
    q_cmd.reps     = in_ch.repeats;
    q_cmd.act      = in_ch.has_action ? in_ch.action_id : 8'd0;
    q_cmd.has_act  = in_ch.has_action;
    q_cmd.nxt      = in_ch.next_flag;
    q_cmd.shape_ok = (in_ch.repeats != 16'd0) && (in_ch.has_action || in_ch.next_flag);
  end
endmodule

// ===== rtl/mnct_queue.sv =====
// Short command queue between front and back end.
// Depends on mnct_pkg.
module mnct_queue import mnct_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t          slots [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [NW-1:0] fill;
  logic          do_push, do_pop;

  assign push_ready = (fill != NW'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop) rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end
endmodule

// ===== rtl/mnct_back.sv =====
// Back end: counter memory, trigger memory, scan and compaction sequencer,
// result register. Depends on mnct_pkg, mnct_out_if and the assertion header.
`include "midi_note_count_trigger_table_assert.svh"
module mnct_back import mnct_pkg::*; #(
  parameter int MAX_TRIGGERS = DEF_MAX_TRIGGERS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] min_vel,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  mnct_out_if.source out_ch
);
  localparam int IW   = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
  localparam int CW   = $clog2(MAX_TRIGGERS + 1);
  localparam int CMPW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NBUMP = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_STRG  = 4'd3;
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_SNXT  = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CWR   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state, state_next;

  logic [COUNT_BITS-1:0] hit_mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] hv;
  logic [COUNT_BITS-1:0] hit_rd;
  logic [NOTE_BITS-1:0]  hit_ra, hit_ra_q;
  logic                  hit_we;
  logic [COUNT_BITS-1:0] hit_wd;
  logic [COUNT_BITS-1:0] cur_cnt;

  trig_t         trig_mem [MAX_TRIGGERS];
  trig_t         trig_rd, trig_wd, ent;
  logic [IW-1:0] trig_ra, trig_wa;
  logic          trig_we;

  logic [CW-1:0]           tcount, scan_i, cr, cw;
  logic [15:0]             nid;
  logic [MAX_TRIGGERS-1:0] fired;
  logic                    any_fired;
  logic [6:0]              cmd_note, cmd_vel;

  res_t pend, outr, new_res;
  logic pend_v, ov, out_free, out_load, can_emit, emit;
  res_t out_d;
  logic add_ok;

  assign out_free = !ov || out_ch.ready;
  assign can_emit = !pend_v || out_free;
  assign cur_cnt  = hv[hit_ra_q] ? hit_rd : '0;
  assign add_ok   = q_cmd.shape_ok && (tcount < CW'(MAX_TRIGGERS));

  always_ff @(posedge clk) begin
    hit_rd   <= hit_mem[hit_ra];
    hit_ra_q <= hit_ra;
    if (hit_we) hit_mem[cmd_note] <= hit_wd;
  end

  always_ff @(posedge clk) begin
    trig_rd <= trig_mem[trig_ra];
    if (trig_we) trig_mem[trig_wa] <= trig_wd;
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    hit_ra     = cmd_note;
    hit_we     = 1'b0;
    hit_wd     = cur_cnt + 1'b1;
    trig_ra    = cr[IW-1:0];
    trig_we    = 1'b0;
    trig_wa    = cw[IW-1:0];
    trig_wd    = trig_rd;
    emit       = 1'b0;
    new_res    = '0;
    out_load   = 1'b0;
    out_d      = pend;
    unique case (state)
      S_IDLE: begin
        hit_ra = q_cmd.note;
        if (q_valid && (q_cmd.op != OP_ADD || out_free)) begin
          q_ready = 1'b1;
          if (q_cmd.op == OP_NOTE) state_next = S_NBUMP;
          if (q_cmd.op == OP_ADD) begin
            out_load     = 1'b1;
            out_d.kind   = add_ok ? KIND_ADDED : KIND_REJECT;
            out_d.act    = q_cmd.act;
            out_d.id     = nid;
            out_d.note   = q_cmd.note;
            out_d.last   = 1'b1;
            trig_we      = add_ok;
            trig_wa      = tcount[IW-1:0];
            trig_wd.note = q_cmd.note;
            trig_wd.reps = q_cmd.reps;
            trig_wd.act  = q_cmd.act;
            trig_wd.has_act = q_cmd.has_act;
            trig_wd.nxt  = q_cmd.nxt;
            trig_wd.id   = nid;
          end
        end
      end
      S_NBUMP: begin
        hit_we     = (cmd_vel > min_vel) && (cur_cnt != '1);
        state_next = S_SRD;
      end
      S_SRD: begin
        trig_ra = IW'(scan_i - 1'b1);
        if (scan_i == '0) state_next = any_fired ? S_CRD : S_FIN;
        else state_next = S_STRG;
      end
      S_STRG: begin
        hit_ra     = trig_rd.note;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        hit_ra = ent.note;
        if (CMPW'(cur_cnt) < CMPW'(ent.reps)) begin
          state_next = S_SRD;
        end else if (ent.has_act) begin
          new_res.kind = KIND_ACTION;
          new_res.act  = ent.act;
          new_res.id   = ent.id;
          new_res.note = ent.note;
          if (can_emit) begin
            emit       = 1'b1;
            state_next = ent.nxt ? S_SNXT : S_SRD;
          end
        end else begin
          state_next = S_SNXT;
        end
      end
      S_SNXT: begin
        new_res.kind = KIND_NEXT;
        new_res.id   = ent.id;
        new_res.note = ent.note;
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_FIN;
        end
      end
      S_CRD: begin
        if (cr == tcount) state_next = S_FIN;
        else if (!fired[cr[IW-1:0]]) state_next = S_CWR;
      end
      S_CWR: begin
        trig_we    = 1'b1;
        state_next = S_CRD;
      end
      S_FIN: begin
        if (!pend_v) state_next = S_IDLE;
        else if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (emit && pend_v) begin
      out_load   = 1'b1;
      out_d.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hv        <= '0;
      tcount    <= '0;
      nid       <= '0;
      fired     <= '0;
      any_fired <= 1'b0;
      pend_v    <= 1'b0;
      ov        <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) ov <= 1'b1;
      else if (out_ch.ready) ov <= 1'b0;
      if (emit) pend_v <= 1'b1;
      else if (state == S_FIN && out_load) pend_v <= 1'b0;
      if (hit_we) hv[cmd_note] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          fired     <= '0;
          any_fired <= 1'b0;
          if (q_ready) begin
            if (q_cmd.op == OP_CLR_CNT) hv <= '0;
            if (q_cmd.op == OP_CLR_ALL) begin
              hv     <= '0;
              tcount <= '0;
              nid    <= '0;
            end
            if (q_cmd.op == OP_ADD && add_ok) begin
              tcount <= tcount + 1'b1;
              nid    <= nid + 16'd1;
            end
          end
        end
        S_NBUMP: scan_i <= tcount;
        S_SRD: begin
          cr <= '0;
          cw <= '0;
          if (scan_i != '0) scan_i <= scan_i - 1'b1;
        end
        S_SCHK: begin
          if (emit) begin
            fired[scan_i[IW-1:0]] <= 1'b1;
            any_fired <= 1'b1;
          end
        end
        S_SNXT: begin
          if (emit) begin
            hv        <= '0;
            tcount    <= '0;
            nid       <= '0;
            any_fired <= 1'b0;
          end
        end
        S_CRD: begin
          if (cr == tcount) tcount <= cw;
          else cr <= cr + 1'b1;
        end
        S_CWR: cw <= cw + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_ready) begin
      cmd_note <= q_cmd.note;
      cmd_vel  <= q_cmd.vel;
    end
    if (state == S_STRG) ent <= trig_rd;
    if (emit) pend <= new_res;
    if (out_load) outr <= out_d;
  end

  assign out_ch.valid         = ov;
  assign out_ch.kind          = outr.kind;
  assign out_ch.action_id_res = outr.act;
  assign out_ch.trigger_id    = outr.id;
  assign out_ch.note_res      = outr.note;
  assign out_ch.last          = outr.last;

  `MNCT_ASSERT(a_tcount_max, clk, rst, tcount <= CW'(MAX_TRIGGERS), "trigger count over limit")
  `MNCT_ASSERT(a_idle_no_pend, clk, rst, (state == S_IDLE) |-> !pend_v, "pending result in idle")
  `MNCT_ASSERT(a_next_clears, clk, rst, (state == S_SNXT && emit) |=> (tcount == '0 && nid == 16'd0), "next did not clear")
  `MNCT_ASSERT_ALWAYS(a_load_free, clk, out_load |-> out_free, "result register overwritten")
endmodule

// ===== rtl/midi_note_count_trigger_table.sv =====
// Top level of the note-count trigger table.
// Depends on mnct_pkg, the channel interfaces, mnct_front, mnct_queue, mnct_back.

// Requests enter a two-entry command queue, which registers them on their way to
// the back end; the back end carries them out one at a time. An add or reset
// request is carried out from the idle state, and an add waits while the result
// register holds a result that is not being taken. A note event bumps the note's
// counter, scans the stored triggers from the newest down (counter and trigger
// memories are read one entry per step), then compacts the table when entries
// fired; any result may also wait on the output.
module midi_note_count_trigger_table import mnct_pkg::*; #(
  parameter int MAX_TRIGGERS = DEF_MAX_TRIGGERS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input logic        clk,
  input logic        rst,
  mnct_in_if.sink    in_ch,
  mnct_out_if.source out_ch,
  mnct_cfg_if.sink   cfg
);
  logic [6:0] min_vel;
  logic       fq_valid, fq_ready, bq_valid, bq_ready;
  cmd_t       fq_cmd, bq_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) min_vel <= MIN_VEL_RESET;
    else if (cfg.valid) min_vel <= cfg.min_velocity;
  end

  mnct_front u_front (
    .in_ch   (in_ch),
    .q_ready (fq_ready),
    .q_valid (fq_valid),
    .q_cmd   (fq_cmd)
  );

  mnct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_cmd    (bq_cmd)
  );

  mnct_back #(
    .MAX_TRIGGERS (MAX_TRIGGERS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .min_vel (min_vel),
    .q_valid (bq_valid),
    .q_ready (bq_ready),
    .q_cmd   (bq_cmd),
    .out_ch  (out_ch)
  );
endmodule

// ===== test/mnct_result_checker.sv =====
// Checker for the note-count trigger table: watches request, result and config channels,
// keeps its own copy of the counters and trigger table and compares every result.
// Depends on mnct_pkg and the channel interfaces.
module mnct_result_checker import mnct_pkg::*; (
  input  logic clk,
  input  logic rst,
  mnct_in_if   in_ch,
  mnct_out_if  out_ch,
  mnct_cfg_if  cfg,
  output int   fails,
  output int   pending,
  output int   n_req,
  output int   n_res
);

  logic [15:0] hits [NOTE_COUNT];
  trig_t       trigs [DEF_MAX_TRIGGERS];
  int          trig_n;
  logic [15:0] id_next;
  logic [6:0]  min_vel;
  res_t        expected_results [$];

  task automatic clear_hits();
    foreach (hits[i]) hits[i] = '0;
  endtask

  task automatic model_request(input op_t op, input logic [6:0] note, input logic [6:0] vel,
                               input logic [15:0] reps, input logic [7:0] act,
                               input logic has_act, input logic nxt);
    res_t  r;
    res_t  batch [$];
    trig_t e;
    int    i;
    bit    ok;
    case (op)
      OP_CLR_CNT: clear_hits();
      OP_CLR_ALL: begin
        clear_hits();
        trig_n = 0;
        id_next = '0;
      end
      OP_ADD: begin
        ok = reps != 0 && (has_act || nxt) && trig_n < DEF_MAX_TRIGGERS;
        r = '{ok ? KIND_ADDED : KIND_REJECT, has_act ? act : 8'd0, id_next, note, 1'b1};
        batch = {batch, r};
        if (ok) begin
          trigs[trig_n] = '{note, reps, act, has_act, nxt, id_next};
          trig_n++;
          id_next++;
        end
      end
      default: begin
        if (vel > min_vel && hits[note] != 16'hFFFF) hits[note]++;
        i = trig_n;
        while (i > 0) begin
          i--;
          e = trigs[i];
          if (hits[e.note] >= e.reps) begin
            if (e.has_act) begin
              r = '{KIND_ACTION, e.act, e.id, e.note, 1'b0};
              batch = {batch, r};
              for (int j = i; j < trig_n - 1; j++) trigs[j] = trigs[j + 1];
              trig_n--;
            end
            if (e.nxt) begin
              r = '{KIND_NEXT, 8'd0, e.id, e.note, 1'b0};
              batch = {batch, r};
              clear_hits();
              trig_n = 0;
              id_next = '0;
              break;
            end
          end
        end
      end
    endcase
    if (batch.size() > 0) begin
      r = batch[batch.size() - 1];
      r.last = 1'b1;
      batch[batch.size() - 1] = r;
    end
    foreach (batch[k]) expected_results = {expected_results, batch[k]};
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      clear_hits();
      trig_n = 0;
      id_next = '0;
      min_vel = MIN_VEL_RESET;
      expected_results.delete();
      fails = 0;
      n_req = 0;
      n_res = 0;
    end else begin
      if (cfg.valid && cfg.ready) min_vel = cfg.min_velocity;
      if (in_ch.valid && in_ch.ready) begin
        n_req++;
        model_request(op_t'(in_ch.mode), in_ch.note, in_ch.velocity, in_ch.repeats,
                      in_ch.action_id, in_ch.has_action, in_ch.next_flag);
      end
      if (out_ch.valid && out_ch.ready) begin
        n_res++;
        if (expected_results.size() == 0) begin
          $error("unexpected result kind %0d trigger_id %0d", out_ch.kind, out_ch.trigger_id);
          fails++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.kind !== e.kind) begin
            $error("kind expected %0d got %0d", e.kind, out_ch.kind);
            fails++;
          end
          if (out_ch.action_id_res !== e.act) begin
            $error("action_id_res expected %0d got %0d", e.act, out_ch.action_id_res);
            fails++;
          end
          if (out_ch.trigger_id !== e.id) begin
            $error("trigger_id expected %0d got %0d", e.id, out_ch.trigger_id);
            fails++;
          end
          if (out_ch.note_res !== e.note) begin
            $error("note_res expected %0d got %0d", e.note, out_ch.note_res);
            fails++;
          end
          if (out_ch.last !== e.last) begin
            $error("last expected %0d got %0d", e.last, out_ch.last);
            fails++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/tb_midi_note_count_trigger_table.sv =====
// Testbench top for the note-count trigger table: clock, reset, directed and random
// requests, result back-pressure and the verdict.
// Depends on mnct_pkg, the channel interfaces, mnct_result_checker and the block.
module tb_midi_note_count_trigger_table;
  import mnct_pkg::*;

  logic clk;
  logic rst;
  int   fails, pending, n_req, n_res;
  bit   no_idle = 0;
  bit   hold_req = 0;
  logic [6:0] pool [4];

  mnct_in_if  in_ch();
  mnct_out_if out_ch();
  mnct_cfg_if cfg();

  midi_note_count_trigger_table dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  mnct_result_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .fails(fails), .pending(pending), .n_req(n_req), .n_res(n_res)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("midi_note_count_trigger_table verification failed");
    $finish;
  end

  task automatic send_req(input op_t op, input logic [6:0] note, input logic [6:0] vel,
                          input logic [15:0] reps, input logic [7:0] act,
                          input logic has_act, input logic nxt);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= op;
    in_ch.note       <= note;
    in_ch.velocity   <= vel;
    in_ch.repeats    <= reps;
    in_ch.action_id  <= act;
    in_ch.has_action <= has_act;
    in_ch.next_flag  <= nxt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_min_vel(input logic [6:0] v);
    drain();
    cfg.valid        <= 1'b1;
    cfg.min_velocity <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_req();
    int          pick;
    logic [6:0]  note;
    logic [15:0] reps;
    pick = $urandom_range(0, 99);
    note = ($urandom_range(0, 9) == 0) ? 7'($urandom) : pool[$urandom_range(0, 3)];
    reps = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if (pick < 45)
      send_req(OP_NOTE, note, 7'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
               1'($urandom));
    else if (pick < 85)
      send_req(OP_ADD, note, 7'($urandom), reps, 8'($urandom), $urandom_range(0, 5) != 0,
               $urandom_range(0, 9) == 0);
    else if (pick < 95)
      send_req(OP_CLR_CNT, 7'($urandom), 7'($urandom), 16'($urandom), 8'($urandom),
               1'($urandom), 1'($urandom));
    else
      send_req(OP_CLR_ALL, 7'($urandom), 7'($urandom), 16'($urandom), 8'($urandom),
               1'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(input int n);
    foreach (pool[i]) pool[i] = 7'($urandom);
    repeat (n) random_req();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = OP_NOTE;
    in_ch.note = '0;
    in_ch.velocity = '0;
    in_ch.repeats = '0;
    in_ch.action_id = '0;
    in_ch.has_action = 1'b0;
    in_ch.next_flag = 1'b0;
    cfg.valid = 1'b0;
    cfg.min_velocity = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset threshold of 1
    send_req(OP_ADD, 7'd0, 7'd0, 16'd0, 8'd3, 1'b1, 1'b0);
    send_req(OP_ADD, 7'd5, 7'd0, 16'd2, 8'd9, 1'b0, 1'b0);
    send_req(OP_ADD, 7'd127, 7'd127, 16'd1, 8'd255, 1'b1, 1'b0);
    send_req(OP_NOTE, 7'd127, 7'd1, 16'd0, 8'd0, 1'b0, 1'b0);
    send_req(OP_NOTE, 7'd127, 7'd127, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    send_req(OP_ADD, 7'd10, 7'd0, 16'd2, 8'h0F, 1'b1, 1'b1);
    send_req(OP_ADD, 7'd10, 7'd0, 16'hFFFF, 8'd7, 1'b1, 1'b0);
    send_req(OP_ADD, 7'd20, 7'd0, 16'd1, 8'hAA, 1'b0, 1'b1);
    send_req(OP_NOTE, 7'd10, 7'd2, 16'd0, 8'd0, 1'b0, 1'b0);
    send_req(OP_CLR_CNT, 7'd0, 7'd0, 16'd0, 8'd0, 1'b0, 1'b0);
    send_req(OP_NOTE, 7'd10, 7'd64, 16'd0, 8'd0, 1'b0, 1'b0);
    send_req(OP_NOTE, 7'd10, 7'd64, 16'd0, 8'd0, 1'b0, 1'b0);
    repeat (33) send_req(OP_ADD, 7'($urandom), 7'd0, 16'd3, 8'($urandom), 1'b1, 1'b0);
    send_req(OP_CLR_ALL, 7'd0, 7'd0, 16'd0, 8'd0, 1'b0, 1'b0);
    send_req(OP_NOTE, 7'd0, 7'd0, 16'd0, 8'd0, 1'b0, 1'b0);

    write_min_vel(7'd0);
    random_phase(15);
    write_min_vel(7'd127);
    hold_req = 1;
    random_phase(15);
    write_min_vel(7'($urandom));
    random_phase(15);

    write_min_vel(7'd1);
    no_idle = 1;
    random_phase(15);
    drain();

    $display("%0d requests and %0d results checked over several velocity thresholds,",
             n_req, n_res);
    $display("including a full table and a long stall on the result side");
    if (fails == 0 && pending == 0)
      $display("midi_note_count_trigger_table verification clean");
    else
      $display("midi_note_count_trigger_table verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mnct_pkg.sv
rtl/mnct_if.sv
rtl/mnct_front.sv
rtl/mnct_queue.sv
rtl/mnct_back.sv
rtl/midi_note_count_trigger_table.sv
test/mnct_result_checker.sv
test/tb_midi_note_count_trigger_table.sv
